>>> design/csim_pkg.sv
// Shared types and constants for the cosine similarity engine.
package csim_pkg;

    localparam int ELEM_BITS = 16;
    localparam int FRAC_BITS = 15;
    localparam int Q_BITS    = 16;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] elem_a;
        logic signed [ELEM_BITS-1:0] elem_b;
        logic                        last_elem;
    } csim_in_t;

    typedef struct packed {
        logic signed [Q_BITS-1:0] similarity;
        logic                     zero_norm;
        logic                     too_long;
    } csim_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_RATIO,
        ST_DELIVER
    } csim_state_t;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_MUL_P,
        RS_MUL_D,
        RS_SUM,
        RS_CMP,
        RS_UPD
    } csim_rstate_t;

    typedef struct packed {
        logic              done;
        logic [Q_BITS-1:0] q;
    } csim_ratio_res_t;

endpackage

>>> design/csim_mac.sv
// Dot product and squared norm accumulators around one shared multiplier.
module csim_mac #(
    parameter int NORM_W = 42
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   clear,
    input  logic signed [csim_pkg::ELEM_BITS-1:0]  elem_a,
    input  logic signed [csim_pkg::ELEM_BITS-1:0]  elem_b,
    output logic                                   done,
    output logic signed [NORM_W:0]                 dot,
    output logic        [NORM_W-1:0]               norm_a,
    output logic        [NORM_W-1:0]               norm_b
);
    import csim_pkg::*;

    localparam int PW = 2 * ELEM_BITS;

    logic                        busy_reg, busy_next;
    logic [1:0]                  step_reg, step_next;
    logic signed [ELEM_BITS-1:0] a_reg, b_reg;
    logic signed [ELEM_BITS-1:0] op_x, op_y;
    logic signed [PW-1:0]        prod;
    logic signed [NORM_W:0]      dot_reg;
    logic [NORM_W-1:0]           na_reg, nb_reg;

    // step 0: a*b, step 1: a*a, step 2: b*b
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_x = a_reg;
                op_y = b_reg;
            end
            2'd1:
            begin
                op_x = a_reg;
                op_y = a_reg;
            end
            default:
            begin
                op_x = b_reg;
                op_y = b_reg;
            end
        endcase
        prod = op_x * op_y;
        done = busy_reg && (step_reg == 2'd2);
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                step_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            dot_reg  <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (clear)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else if (busy_reg)
            begin
                case (step_reg)
                    2'd0:    dot_reg <= dot_reg + {{(NORM_W+1-PW){prod[PW-1]}}, prod};
                    2'd1:    na_reg  <= na_reg + {{(NORM_W-PW){1'b0}}, prod};
                    default: nb_reg  <= nb_reg + {{(NORM_W-PW){1'b0}}, prod};
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= elem_a;
            b_reg <= elem_b;
        end
    end

    assign dot    = dot_reg;
    assign norm_a = na_reg;
    assign norm_b = nb_reg;

endmodule

>>> design/csim_ratio.sv
// Shift-add unit for the exact truncated ratio |dot| / sqrt(norm_a * norm_b).
module csim_ratio #(
    parameter int NORM_W = 42
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NORM_W:0]                  dmag,
    input  logic [NORM_W-1:0]                norm_a,
    input  logic [NORM_W-1:0]                norm_b,
    output csim_pkg::csim_ratio_res_t        res
);
    import csim_pkg::*;

    localparam int DW    = NORM_W + 1;
    localparam int SH    = 2 * FRAC_BITS;
    localparam int W     = 2 * DW + SH + 4;
    localparam int CNT_W = $clog2(DW + 1);

    csim_rstate_t      st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      mcand_reg, mcand_next;
    logic [DW-1:0]     mplr_reg, mplr_next;
    logic [W-1:0]      acc_reg, acc_next;   // product, then q^2 * P
    logic [W-1:0]      ps_reg, ps_next;     // P << 2k
    logic [W-1:0]      qps_reg, qps_next;   // q*P << (k+1)
    logic [W-1:0]      r_reg, r_next;       // dmag^2 << 30
    logic [W-1:0]      t_reg, t_next;
    logic [Q_BITS-1:0] q_reg, q_next;
    logic [W-1:0]      add_a, add_b, add_s;
    logic              done_next, done_reg;

    assign add_s = add_a + add_b;

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        acc_next   = acc_reg;
        ps_next    = ps_reg;
        qps_next   = qps_reg;
        r_next     = r_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        add_a      = acc_reg;
        add_b      = mplr_reg[0] ? mcand_reg : '0;
        case (st_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    mcand_next = W'(norm_a);
                    mplr_next  = DW'(norm_b);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(DW);
                    st_next    = RS_MUL_P;
                end
            end
            RS_MUL_P, RS_MUL_D:
            begin
                acc_next   = add_s;
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    if (st_reg == RS_MUL_P)
                    begin
                        ps_next    = add_s << SH;
                        mcand_next = W'(dmag);
                        mplr_next  = dmag;
                        acc_next   = '0;
                        cnt_next   = CNT_W'(DW);
                        st_next    = RS_MUL_D;
                    end
                    else
                    begin
                        r_next   = add_s << SH;
                        acc_next = '0;
                        qps_next = '0;
                        q_next   = '0;
                        cnt_next = CNT_W'(Q_BITS - 1);
                        st_next  = RS_SUM;
                    end
                end
            end
            RS_SUM:
            begin
                add_a   = qps_reg;
                add_b   = ps_reg;
                t_next  = add_s;
                st_next = RS_CMP;
            end
            RS_CMP:
            begin
                add_a = acc_reg;
                add_b = t_reg;
                if (add_s <= r_reg)
                begin
                    acc_next = add_s;
                    q_next   = q_reg | (Q_BITS'(1) << cnt_reg);
                    st_next  = RS_UPD;
                end
                else
                begin
                    qps_next = qps_reg >> 1;
                    ps_next  = ps_reg >> 2;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        done_next = 1'b1;
                        st_next   = RS_IDLE;
                    end
                    else
                    begin
                        st_next = RS_SUM;
                    end
                end
            end
            RS_UPD:
            begin
                add_a    = qps_reg;
                add_b    = ps_reg << 1;
                qps_next = add_s >> 1;
                ps_next  = ps_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next = 1'b1;
                    st_next   = RS_IDLE;
                end
                else
                begin
                    st_next = RS_SUM;
                end
            end
            default:
            begin
                st_next = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= RS_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        acc_reg   <= acc_next;
        ps_reg    <= ps_next;
        qps_reg   <= qps_next;
        r_reg     <= r_next;
        t_reg     <= t_next;
        q_reg     <= q_next;
    end

    assign res.done = done_reg;
    assign res.q    = q_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == RS_IDLE)
        else $error("ratio started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> st_reg == RS_IDLE)
        else $error("done without returning to idle");
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == RS_SUM) |-> acc_reg <= r_reg)
        else $error("partial square exceeds bound");
`endif

endmodule

>>> design/cosine_similarity_engine.sv
// Top level of the cosine similarity engine: handshakes, sequencing, result register.
//
//  channel | signals                    | payload
//  in      | in_valid / in_ready        | in_item  (elem_a, elem_b, last_elem)
//  out     | out_valid / out_ready      | out_item (similarity, zero_norm, too_long)
//
// An element pair passes through accept, three turns of one 16x16 multiplier, then a check.
// A last pair adds two shift-add multiplies in the ratio unit, then the square root search
// over the 16 result bits.
// rst_n clears all sums and control; no clearing pass is needed.
// A result waits in the output register; further items are taken meanwhile.
module cosine_similarity_engine #(
    parameter int MAX_LEN = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csim_pkg::csim_in_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output csim_pkg::csim_out_t out_item
);
    import csim_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int NORM_W = 2 * ELEM_BITS - 1 + CNT_W;

    csim_state_t            st_reg, st_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;
    logic                   neg_reg, neg_next;
    logic signed [Q_BITS-1:0] sim_reg, sim_next;
    logic                   zero_reg, zero_next;
    logic                   ov_reg, ov_next;
    csim_out_t              oi_reg, oi_next;

    logic                   accept;
    logic                   mac_start, mac_clear, mac_done;
    logic signed [NORM_W:0] dot;
    logic [NORM_W-1:0]      norm_a, norm_b;
    logic [NORM_W:0]        dmag;
    logic                   ratio_start;
    csim_ratio_res_t        rres;
    logic [Q_BITS-1:0]      qv;

    assign in_ready = (st_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign dmag     = dot[NORM_W] ? (NORM_W+1)'(-dot) : dot;
    assign qv       = rres.q;

    csim_mac #(.NORM_W(NORM_W)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .clear  (mac_clear),
        .elem_a (in_item.elem_a),
        .elem_b (in_item.elem_b),
        .done   (mac_done),
        .dot    (dot),
        .norm_a (norm_a),
        .norm_b (norm_b)
    );

    csim_ratio #(.NORM_W(NORM_W)) u_ratio (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ratio_start),
        .dmag   (dmag),
        .norm_a (norm_a),
        .norm_b (norm_b),
        .res    (rres)
    );

    always_comb
    begin
        st_next     = st_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        neg_next    = neg_reg;
        sim_next    = sim_reg;
        zero_next   = zero_reg;
        ov_next     = ov_reg;
        oi_next     = oi_reg;
        mac_start   = 1'b0;
        mac_clear   = 1'b0;
        ratio_start = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_item.last_elem;
                    if (count_reg < CNT_W'(MAX_LEN))
                    begin
                        mac_start  = 1'b1;
                        count_next = count_reg + 1'b1;
                        st_next    = ST_ACC;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        st_next  = ST_CHECK;
                    end
                end
            end
            ST_ACC:
            begin
                if (mac_done)
                begin
                    st_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!last_reg)
                begin
                    st_next = ST_IDLE;
                end
                else if (norm_a == '0 || norm_b == '0)
                begin
                    sim_next  = '0;
                    zero_next = 1'b1;
                    st_next   = ST_DELIVER;
                end
                else
                begin
                    zero_next   = 1'b0;
                    neg_next    = dot[NORM_W];
                    ratio_start = 1'b1;
                    st_next     = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                if (rres.done)
                begin
                    // +1.0 saturates; -1.0 is representable
                    if (neg_reg)
                    begin
                        sim_next = qv[Q_BITS-1] ? {1'b1, {(Q_BITS-1){1'b0}}} : -qv;
                    end
                    else
                    begin
                        sim_next = qv[Q_BITS-1] ? {1'b0, {(Q_BITS-1){1'b1}}} : qv;
                    end
                    st_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!ov_reg || out_ready)
                begin
                    oi_next.similarity = sim_reg;
                    oi_next.zero_norm  = zero_reg;
                    oi_next.too_long   = ovf_reg;
                    ov_next    = 1'b1;
                    mac_clear  = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    st_next    = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        neg_reg  <= neg_next;
        sim_reg  <= sim_next;
        zero_reg <= zero_next;
        oi_reg   <= oi_next;
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("pair count beyond limit");
    a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oi_reg.zero_norm) |-> oi_reg.similarity == '0)
        else $error("zero norm with nonzero similarity");
    a_ratio_start: assert property (@(posedge clk) disable iff (!rst_n)
        ratio_start |-> (st_reg == ST_CHECK && last_reg))
        else $error("ratio started outside final check");
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        mac_clear |=> (count_reg == '0 && !ovf_reg))
        else $error("accumulators not restarted after result");
`endif

endmodule
